// File: design/rounded_rect_coverage_top_macros.svh
// Assertion macros for the rounded rectangle coverage block.
// Uses the clk_i and rst_ni names of the including module.
`ifndef ROUNDED_RECT_COVERAGE_TOP_MACROS_SVH
`define ROUNDED_RECT_COVERAGE_TOP_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define RRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that an antecedent implies a consequent on the same edge.
`define RRC_ASSERT_IMP(label, ante, cons, msg) \
  `RRC_ASSERT(label, (ante) |-> (cons), msg)

`endif

// File: design/rrc_pkg.sv
// Shared types and constants of the rounded rectangle coverage block.
// No dependencies.
package rrc_pkg;

  localparam int unsigned XY_W       = 10;
  localparam int unsigned IDX_W      = 20;
  localparam int unsigned BUF_W      = 11;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned SIZE_W     = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [BUF_W-1:0] BUF_WIDTH_RST  = BUF_W'(80);
  localparam logic [BUF_W-1:0] BUF_HEIGHT_RST = BUF_W'(30);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUF_WIDTH   = 3'd0,
    CFG_BUF_HEIGHT  = 3'd1,
    CFG_RECT_LEFT   = 3'd2,
    CFG_RECT_TOP    = 3'd3,
    CFG_RECT_WIDTH  = 3'd4,
    CFG_RECT_HEIGHT = 3'd5,
    CFG_RADIUS_X    = 3'd6,
    CFG_RADIUS_Y    = 3'd7
  } cfg_idx_e;

endpackage

// File: design/rounded_rect_coverage_top.sv
// Top level of the rounded rectangle coverage block: a five stage pipeline.
// Depends on rrc_pkg and rounded_rect_coverage_top_macros.svh.
`include "rounded_rect_coverage_top_macros.svh"

// One pixel coordinate is taken in every clock cycle and busy stays low.
// Its result appears on done_o for one cycle, since the receiver cannot
// stall. The result passes through five register stages: bounds and
// inner box, corner distances, the radius products, their squares, and
// the final compare. Configuration writes take effect on the next clock
// edge.
module rounded_rect_coverage_top import rrc_pkg::*; #(
  parameter int unsigned FRAC_BITS = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [XY_W-1:0]        pixel_x_i,
  input  logic [XY_W-1:0]        pixel_y_i,
  output logic                   done_o,
  output logic                   covered_o,
  output logic [IDX_W-1:0]       pixel_index_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int unsigned CW = (FRAC_BITS + 11 > 18) ? FRAC_BITS + 11 : 18;
  localparam int unsigned AW = (FRAC_BITS < 15) ? 16 : FRAC_BITS + 2;
  localparam int unsigned UW = AW + SIZE_W;
  localparam int unsigned SW = 2 * UW;
  localparam int unsigned RW = 2 * SIZE_W;
  localparam int unsigned PW = XY_W + BUF_W;
  localparam logic [CW-1:0] HALF = CW'(1) << (FRAC_BITS - 1);

  logic [BUF_W-1:0]  buf_width_q, buf_height_q;
  logic [POS_W-1:0]  rect_left_q, rect_top_q;
  logic [SIZE_W-1:0] rect_width_q, rect_height_q, radius_x_q, radius_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_width_q   <= BUF_WIDTH_RST;
      buf_height_q  <= BUF_HEIGHT_RST;
      rect_left_q   <= '0;
      rect_top_q    <= '0;
      rect_width_q  <= '0;
      rect_height_q <= '0;
      radius_x_q    <= '0;
      radius_y_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BUF_WIDTH:   buf_width_q   <= cfg_wdata_i[BUF_W-1:0];
        CFG_BUF_HEIGHT:  buf_height_q  <= cfg_wdata_i[BUF_W-1:0];
        CFG_RECT_LEFT:   rect_left_q   <= cfg_wdata_i[POS_W-1:0];
        CFG_RECT_TOP:    rect_top_q    <= cfg_wdata_i[POS_W-1:0];
        CFG_RECT_WIDTH:  rect_width_q  <= cfg_wdata_i[SIZE_W-1:0];
        CFG_RECT_HEIGHT: rect_height_q <= cfg_wdata_i[SIZE_W-1:0];
        CFG_RADIUS_X:    radius_x_q    <= cfg_wdata_i[SIZE_W-1:0];
        CFG_RADIUS_Y:    radius_y_q    <= cfg_wdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pixel range along one axis is [start, end), with end clipped to the buffer.
  function automatic logic axis_in(input logic [XY_W-1:0] pos,
                                   input logic [POS_W-1:0] org,
                                   input logic [SIZE_W-1:0] size,
                                   input logic [BUF_W-1:0] lim);
    logic [17:0] e;
    logic [16:0] st;
    logic [16:0] en;
    e  = {{2{org[POS_W-1]}}, org} + {3'b000, size};
    st = org[POS_W-1] ? '0 : (17'(org) >> FRAC_BITS);
    en = e[17] ? '0 : (e[16:0] >> FRAC_BITS);
    return (17'(pos) >= st) && (17'(pos) < en) && ({1'b0, pos} < lim);
  endfunction

  assign busy = 1'b0;

  // Stage 1: bounds test, pixel centre, inner box edges and row offset.
  logic              v1_q;
  logic              inb1_q;
  logic [CW-1:0]     px1_q, py1_q, il1_q, ir1_q, it1_q, ib1_q;
  logic [PW-1:0]     row1_q;
  logic [XY_W-1:0]   x1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    inb1_q <= axis_in(pixel_x_i, rect_left_q, rect_width_q, buf_width_q) &&
              axis_in(pixel_y_i, rect_top_q, rect_height_q, buf_height_q);
    px1_q  <= (CW'(pixel_x_i) << FRAC_BITS) | HALF;
    py1_q  <= (CW'(pixel_y_i) << FRAC_BITS) | HALF;
    il1_q  <= CW'($signed(rect_left_q)) + CW'(radius_x_q);
    ir1_q  <= CW'($signed(rect_left_q)) + CW'(rect_width_q) - CW'(radius_x_q);
    it1_q  <= CW'($signed(rect_top_q)) + CW'(radius_y_q);
    ib1_q  <= CW'($signed(rect_top_q)) + CW'(rect_height_q) - CW'(radius_y_q);
    row1_q <= PW'(pixel_y_i) * PW'(buf_width_q);
    x1_q   <= pixel_x_i;
  end

  // Stage 2: corner region and distances past the inner box.
  logic [CW-1:0] dl, dr, dt, db;
  logic          lx, gx, ty, by, corner, zr;

  always_comb begin
    dl     = il1_q - px1_q;
    dr     = px1_q - ir1_q;
    dt     = it1_q - py1_q;
    db     = py1_q - ib1_q;
    lx     = !dl[CW-1] && (dl != '0);
    gx     = !dr[CW-1] && (dr != '0);
    ty     = !dt[CW-1] && (dt != '0);
    by     = !db[CW-1] && (db != '0);
    corner = (lx || gx) && (ty || by);
    zr     = (radius_x_q == '0) || (radius_y_q == '0);
  end

  logic             v2_q;
  logic             pre2_q, need2_q;
  logic [AW-1:0]    a2_q, b2_q;
  logic [IDX_W-1:0] idx2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pre2_q  <= inb1_q && !(corner && zr);
    need2_q <= inb1_q && corner && !zr;
    a2_q    <= lx ? dl[AW-1:0] : dr[AW-1:0];
    b2_q    <= ty ? dt[AW-1:0] : db[AW-1:0];
    idx2_q  <= IDX_W'(row1_q + PW'(x1_q));
  end

  // Stage 3: distances scaled by the opposite radius, and the radius product.
  logic             v3_q, pre3_q, need3_q;
  logic [UW-1:0]    ua3_q, ub3_q;
  logic [RW-1:0]    r3_q;
  logic [IDX_W-1:0] idx3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ua3_q   <= UW'(a2_q) * UW'(radius_y_q);
    ub3_q   <= UW'(b2_q) * UW'(radius_x_q);
    r3_q    <= RW'(radius_x_q) * RW'(radius_y_q);
    pre3_q  <= pre2_q;
    need3_q <= need2_q;
    idx3_q  <= idx2_q;
  end

  // Stage 4: squares.
  logic             v4_q, pre4_q, need4_q;
  logic [SW-1:0]    ua4_q, ub4_q;
  logic [2*RW-1:0]  r4_q;
  logic [IDX_W-1:0] idx4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ua4_q   <= SW'(ua3_q) * SW'(ua3_q);
    ub4_q   <= SW'(ub3_q) * SW'(ub3_q);
    r4_q    <= (2*RW)'(r3_q) * (2*RW)'(r3_q);
    pre4_q  <= pre3_q;
    need4_q <= need3_q;
    idx4_q  <= idx3_q;
  end

  // Stage 5: ellipse compare and result register.
  logic [SW:0]      sum;
  logic             outside;
  logic             done_q, covered_q;
  logic [IDX_W-1:0] idx_q;

  always_comb begin
    sum     = (SW+1)'(ua4_q) + (SW+1)'(ub4_q);
    outside = sum > (SW+1)'(r4_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    covered_q <= pre4_q && !(need4_q && outside);
    idx_q     <= idx4_q;
  end

  assign done_o        = done_q;
  assign covered_o     = covered_q;
  assign pixel_index_o = idx_q;

  `RRC_ASSERT_IMP(a_done_follows_start, done_o, $past(start, 5), "result beat without start")
  `RRC_ASSERT(a_outside_uncovered, (v2_q && !pre2_q) |-> ##3 !covered_o, "uncovered pixel flagged")
  `RRC_ASSERT_IMP(a_need_implies_pre, v2_q && need2_q, pre2_q, "ellipse test outside bounds")

endmodule
